[hw/rtl/tfd_pkg.sv]
// Shared types and constants for the tagged frame deframer.
// No dependencies; every other file in hw/rtl refers to this package by scoped name.
`timescale 1ns / 1ps

package tfd_pkg;

   localparam int MAX_PAYLOAD = 260;
   localparam int LEN_W       = 16;
   localparam int LEFT_W      = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0]       TAG_BYTE        = 8'hAA;
   localparam logic [LEN_W-1:0] HUNT_LIMIT_RST  = 16'd1000;
   localparam logic [LEN_W-1:0] MAX_PAYLOAD_LEN = LEN_W'(MAX_PAYLOAD);

   // beat command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // end-of-frame status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CHK_ERR  = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;
   localparam logic [1:0] ST_TIMEOUT  = 2'd3;

   // register indexes
   localparam logic REG_HUNT_LIMIT = 1'b0;

   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic [1:0]       status;
      logic [LEN_W-1:0] frame_length;
      logic             last;
   } res_type;

endpackage

[hw/rtl/tfd_csr.sv]
// Configuration register block: holds the hunt budget.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output logic [tfd_pkg::LEN_W-1:0] hunt_limit
);

   logic [tfd_pkg::LEN_W-1:0] hunt_limit_ff;
   logic [tfd_pkg::LEN_W-1:0] hunt_limit_in;
   logic                      wr_en;

   assign wr_en = psel & penable & pwrite & (paddr[2] == tfd_pkg::REG_HUNT_LIMIT);

   always_comb begin
      hunt_limit_in = hunt_limit_ff;
      if (wr_en) begin
         hunt_limit_in = pwdata[tfd_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_limit_ff <= tfd_pkg::HUNT_LIMIT_RST;
      end else begin
         hunt_limit_ff <= hunt_limit_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == tfd_pkg::REG_HUNT_LIMIT) begin
         prdata = {{(32 - tfd_pkg::LEN_W){1'b0}}, hunt_limit_ff};
      end
   end

   assign pready     = 1'b1;
   assign hunt_limit = hunt_limit_ff;

endmodule

[hw/rtl/tfd_core.sv]
// Input register and frame state machine: hunts the tag, reads the length,
// passes payload and checks the XOR byte. Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [7:0]                req_rx_byte,
   input  logic [tfd_pkg::LEN_W-1:0] hunt_limit,
   input  logic                      q_full,
   output logic                      res_vld,
   output tfd_pkg::res_type          res
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HUNT,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic                       in_vld_ff, in_vld_in;
   logic                       cmd_ff, cmd_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [tfd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [tfd_pkg::LEFT_W-1:0] left_ff, left_in;
   logic [7:0]                 xor_ff, xor_in;
   logic [tfd_pkg::LEN_W-1:0]  hunt_ff, hunt_in;
   logic                       fire;
   logic [tfd_pkg::LEN_W-1:0]  full_len;
   logic [tfd_pkg::LEN_W-1:0]  hunt_inc;

   assign fire      = in_vld_ff & ~q_full;
   assign req_ready = ~in_vld_ff | fire;
   assign full_len  = {len_ff[15:8], byte_ff};
   assign hunt_inc  = hunt_ff + tfd_pkg::LEN_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      xor_in    = xor_ff;
      hunt_in   = hunt_ff;
      res_vld   = 1'b0;
      res       = '0;
      in_vld_in = in_vld_ff;
      cmd_in    = cmd_ff;
      byte_in   = byte_ff;

      if (req_ready) begin
         in_vld_in = req_valid;
         cmd_in    = req_cmd;
         byte_in   = req_rx_byte;
      end

      if (fire) begin
         if (cmd_ff == tfd_pkg::CMD_START) begin
            // rearm: drop any frame in progress
            phase_in = PH_HUNT;
            len_in   = '0;
            left_in  = '0;
            xor_in   = '0;
            hunt_in  = '0;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (byte_ff == tfd_pkg::TAG_BYTE) begin
                     phase_in = PH_LEN_HI;
                  end else begin
                     hunt_in = hunt_inc;
                     if (hunt_inc >= hunt_limit) begin
                        phase_in         = PH_IDLE;
                        res_vld          = 1'b1;
                        res.kind         = tfd_pkg::KIND_STATUS;
                        res.status       = tfd_pkg::ST_TIMEOUT;
                        res.last         = 1'b1;
                     end
                  end
               end
               PH_LEN_HI: begin
                  len_in   = {byte_ff, 8'd0};
                  phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  len_in = full_len;
                  if (full_len > tfd_pkg::MAX_PAYLOAD_LEN) begin
                     phase_in         = PH_IDLE;
                     res_vld          = 1'b1;
                     res.kind         = tfd_pkg::KIND_STATUS;
                     res.status       = tfd_pkg::ST_TOO_LONG;
                     res.frame_length = full_len;
                     res.last         = 1'b1;
                  end else begin
                     left_in  = full_len[tfd_pkg::LEFT_W-1:0];
                     xor_in   = '0;
                     phase_in = (full_len == '0) ? PH_CHECK : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  xor_in   = xor_ff ^ byte_ff;
                  left_in  = left_ff - tfd_pkg::LEFT_W'(1);
                  if (left_ff == tfd_pkg::LEFT_W'(1)) begin
                     phase_in = PH_CHECK;
                  end
                  res_vld  = 1'b1;
                  res.kind = tfd_pkg::KIND_PAYLOAD;
                  res.data = byte_ff;
               end
               PH_CHECK: begin
                  phase_in         = PH_IDLE;
                  res_vld          = 1'b1;
                  res.kind         = tfd_pkg::KIND_STATUS;
                  res.status       = (byte_ff == xor_ff) ? tfd_pkg::ST_OK
                                                         : tfd_pkg::ST_CHK_ERR;
                  res.frame_length = len_ff;
                  res.last         = 1'b1;
               end
               default: begin
                  // not armed: ignore the byte
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         in_vld_ff <= 1'b0;
         len_ff    <= '0;
         left_ff   <= '0;
         xor_ff    <= '0;
         hunt_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         in_vld_ff <= in_vld_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         xor_ff    <= xor_in;
         hunt_ff   <= hunt_in;
      end
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
   end

   a_res_needs_beat: assert property (@(posedge clock) disable iff (reset)
      res_vld |-> (in_vld_ff && !q_full && cmd_ff == tfd_pkg::CMD_BYTE))
      else $error("result without a byte beat");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      (res_vld && res.kind == tfd_pkg::KIND_PAYLOAD) |->
      (res.last == 1'b0 && res.status == tfd_pkg::ST_OK && res.frame_length == '0))
      else $error("payload beat carries status fields");

   a_status_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (res_vld && res.kind == tfd_pkg::KIND_STATUS) |=> (phase_ff == PH_IDLE))
      else $error("status beat did not end the frame");

   a_left_bounded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != '0 &&
      tfd_pkg::LEN_W'(left_ff) <= tfd_pkg::MAX_PAYLOAD_LEN))
      else $error("payload count out of range");

endmodule

[hw/rtl/tfd_outq.sv]
// Two-entry result queue: decouples the frame logic from result stalls.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tfd_pkg::res_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tfd_pkg::res_type rsp_data
);

   tfd_pkg::res_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             pop;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid & rsp_ready;
   assign rsp_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full result queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

endmodule

[hw/rtl/tagged_frame_deframer_xor_check.sv]
// Top level of the tagged frame deframer with XOR check.
// Depends on tfd_pkg, tfd_csr, tfd_core and tfd_outq.
//
//   Channel | Direction | Handshake             | Beat carries
//   req     | in        | req_valid/req_ready   | cmd, rx_byte
//   rsp     | out       | rsp_valid/rsp_ready   | kind, data, status, frame_length, last
//   csr     | in/out    | APB setup + access    | hunt_limit at byte address 0
//
// One request beat per cycle is taken while the result queue is not full; a beat's result is
// registered in the input register, then in the result queue, before it shows on rsp.
// The frame state advances once per beat in a single pass between those registers.
// Reset is synchronous: phase idle and unarmed, counters clear, hunt_limit 1000.
// A stalled rsp side fills the two-entry result queue before req_ready drops.
`timescale 1ns / 1ps

module tagged_frame_deframer_xor_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [tfd_pkg::LEN_W-1:0] hunt_limit;
   logic                      q_full;
   logic                      res_vld;
   tfd_pkg::res_type          res;
   tfd_pkg::res_type          out_res;

   tfd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .hunt_limit (hunt_limit)
   );

   tfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_rx_byte (req_rx_byte),
      .hunt_limit  (hunt_limit),
      .q_full      (q_full),
      .res_vld     (res_vld),
      .res         (res)
   );

   tfd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_vld),
      .push_data (res),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_res)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_data         = out_res.data;
   assign rsp_status       = out_res.status;
   assign rsp_frame_length = out_res.frame_length;
   assign rsp_last         = out_res.last;

endmodule

[verif/deframer_checker.sv]
// Checker for the tagged frame deframer: watches the req, rsp and csr ports,
// predicts every result beat and compares it field by field. Depends on tfd_pkg.
`timescale 1ns / 1ps

module deframer_checker
   import tfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_kind,
   input  logic [7:0]  rsp_data,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_frame_length,
   input  logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          outstanding,
   output int          fail_count
);

   typedef enum logic [2:0] {
      IDLE_S, HUNT_S, LEN_HI_S, LEN_LO_S, BODY_S, CHECK_S
   } frame_phase_type;

   localparam logic [2:0] HUNT_LIMIT_ADDR = {REG_HUNT_LIMIT, 2'b00};

   frame_phase_type frame_ph;
   logic [15:0]  hunt_limit;
   logic [15:0]  hdr_len;
   logic [15:0]  body_left;
   logic [15:0]  hunt_count;
   logic [7:0]   running_xor;
   res_type      pending_beats[$];
   int           err_total = 0;

   assign fail_count = err_total;

   // Advance the frame state by one accepted beat; returns 1 when a result beat is due.
   function automatic bit deframe_beat(input logic cmd, input logic [7:0] b, output res_type r);
      bit produced;
      produced = 1'b0;
      r = '0;
      if (cmd == CMD_START) begin
         frame_ph    = HUNT_S;
         hdr_len     = '0;
         body_left   = '0;
         running_xor = '0;
         hunt_count  = '0;
      end else begin
         case (frame_ph)
            HUNT_S: begin
               if (b == TAG_BYTE) begin
                  frame_ph = LEN_HI_S;
               end else begin
                  hunt_count = hunt_count + 16'd1;
                  if (hunt_count >= hunt_limit) begin
                     r.kind   = KIND_STATUS;
                     r.status = ST_TIMEOUT;
                     r.last   = 1'b1;
                     frame_ph = IDLE_S;
                     produced = 1'b1;
                  end
               end
            end
            LEN_HI_S: begin
               hdr_len  = {b, 8'h00};
               frame_ph = LEN_LO_S;
            end
            LEN_LO_S: begin
               hdr_len[7:0] = b;
               if (hdr_len > MAX_PAYLOAD_LEN) begin
                  r.kind         = KIND_STATUS;
                  r.status       = ST_TOO_LONG;
                  r.frame_length = hdr_len;
                  r.last         = 1'b1;
                  frame_ph       = IDLE_S;
                  produced       = 1'b1;
               end else begin
                  body_left   = hdr_len;
                  running_xor = '0;
                  frame_ph    = (hdr_len == 0) ? CHECK_S : BODY_S;
               end
            end
            BODY_S: begin
               running_xor = running_xor ^ b;
               body_left   = body_left - 16'd1;
               if (body_left == 0) frame_ph = CHECK_S;
               r.kind   = KIND_PAYLOAD;
               r.data   = b;
               produced = 1'b1;
            end
            CHECK_S: begin
               r.kind         = KIND_STATUS;
               r.status       = (b == running_xor) ? ST_OK : ST_CHK_ERR;
               r.frame_length = hdr_len;
               r.last         = 1'b1;
               frame_ph       = IDLE_S;
               produced       = 1'b1;
            end
            default: ;
         endcase
      end
      return produced;
   endfunction

   function automatic void check_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", fname, want_v, got_v);
         err_total++;
      end
   endfunction

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         hunt_limit  = HUNT_LIMIT_RST;
         frame_ph    = IDLE_S;
         hdr_len     = '0;
         body_left   = '0;
         running_xor = '0;
         hunt_count  = '0;
         pending_beats.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == HUNT_LIMIT_ADDR) begin
            if (csr_pwrite) begin
               hunt_limit = csr_pwdata[15:0];
            end else if (csr_prdata !== {16'h0000, hunt_limit}) begin
               $error("hunt_limit readback: expected %0d, got %0d", hunt_limit, csr_prdata);
               err_total++;
            end
         end
         if (req_valid && req_ready) begin
            if (deframe_beat(req_cmd, req_rx_byte, want)) pending_beats.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_beats.size() == 0) begin
               $error("result beat with nothing expected: kind %0d data %0d status %0d",
                      rsp_kind, rsp_data, rsp_status);
               err_total++;
            end else begin
               want = pending_beats.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("data", 16'(want.data), 16'(rsp_data));
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("frame_length", want.frame_length, rsp_frame_length);
               check_field("last", 16'(want.last), 16'(rsp_last));
            end
         end
      end
      outstanding <= pending_beats.size();
   end

endmodule

[verif/tb.sv]
// Testbench top for the tagged frame deframer: clock, reset, request beats,
// hunt_limit writes and the verdict. Depends on tfd_pkg, the block and deframer_checker.
`timescale 1ns / 1ps

module tb;
   import tfd_pkg::*;

   localparam int         PHASE_BEATS     = 275;
   localparam int         NUM_PHASES      = 6;
   localparam int         CYCLE_LIMIT     = 1000000;
   localparam int         DRAIN_CYCLES    = 8;
   localparam logic [2:0] HUNT_LIMIT_ADDR = {REG_HUNT_LIMIT, 2'b00};

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic        req_cmd     = CMD_START;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_frame_length;
   logic        rsp_last;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          outstanding;
   int          fail_count;
   int unsigned cycle_count = 0;
   int unsigned beats_sent  = 0;
   int unsigned rsp_hold    = 0;
   bit          req_calm    = 1'b0;
   bit          rsp_calm    = 1'b0;
   logic [15:0] hunt_limit_now;

   logic [8:0] directed_beats [29] = '{
      {CMD_BYTE, 8'h55},      // not armed: ignored
      {CMD_START, 8'hFF},
      {CMD_BYTE, 8'h00},
      {CMD_BYTE, TAG_BYTE},
      {CMD_BYTE, 8'h00},
      {CMD_BYTE, 8'h02},
      {CMD_BYTE, 8'hFF},
      {CMD_BYTE, 8'h00},
      {CMD_BYTE, 8'hFF},      // good check byte
      {CMD_BYTE, 8'h12},      // idle after the status: ignored
      {CMD_START, 8'h00},
      {CMD_BYTE, TAG_BYTE},
      {CMD_BYTE, 8'h00},
      {CMD_BYTE, 8'h00},      // empty payload
      {CMD_BYTE, 8'h01},      // bad check against zero
      {CMD_START, 8'hAA},
      {CMD_BYTE, TAG_BYTE},
      {CMD_BYTE, 8'hFF},
      {CMD_BYTE, 8'hFF},      // largest length
      {CMD_START, 8'h00},
      {CMD_BYTE, TAG_BYTE},
      {CMD_BYTE, 8'h01},
      {CMD_BYTE, 8'h05},      // one past the payload limit
      {CMD_START, 8'h00},
      {CMD_BYTE, TAG_BYTE},
      {CMD_BYTE, 8'h01},
      {CMD_BYTE, 8'h04},
      {CMD_BYTE, TAG_BYTE},   // tag value inside the payload
      {CMD_START, 8'h00}      // drop the frame in progress
   };

   tagged_frame_deframer_xor_check DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   deframer_checker frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .outstanding      (outstanding),
      .fail_count       (fail_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: stall a random number of cycles after each beat, with calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_ready && rsp_valid) begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         rsp_hold = rsp_calm ? 0 : $urandom_range(0, 18);
         rsp_ready <= (rsp_hold == 0);
      end else if (!rsp_ready) begin
         if (rsp_hold <= 1) begin
            rsp_hold = 0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_hold = rsp_hold - 1;
         end
      end
   end

   task automatic send_beat(input logic cmd, input logic [7:0] b);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // Drain, then write hunt_limit and read it back.
   task automatic set_hunt_limit(input logic [15:0] new_limit);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= HUNT_LIMIT_ADDR;
      csr_pwdata  <= {16'h0000, new_limit};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      hunt_limit_now = new_limit;
   endtask

   task automatic send_frame();
      int unsigned pick;
      int unsigned noise;
      int unsigned cut;
      int unsigned i;
      logic [7:0]  b;
      logic [7:0]  xsum;
      logic [15:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // loose beats: any command, any byte
         repeat ($urandom_range(1, 6)) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
         return;
      end
      send_beat(CMD_START, 8'($urandom));
      pick  = $urandom_range(0, 9);
      noise = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 4) : $urandom_range(5, 45);
      for (i = 1; i <= noise; i++) begin
         b = 8'($urandom);
         if (b == TAG_BYTE) b = ~b;
         send_beat(CMD_BYTE, b);
         if (i >= hunt_limit_now) return;   // timeout ends the frame
      end
      send_beat(CMD_BYTE, TAG_BYTE);
      pick = $urandom_range(0, 99);
      if (pick < 36)      len = 16'($urandom_range(0, 3));
      else if (pick < 72) len = 16'($urandom_range(4, 16));
      else if (pick < 88) len = 16'($urandom_range(17, 64));
      else if (pick < 90) len = MAX_PAYLOAD_LEN - 16'($urandom_range(0, 1));
      else if (pick < 95) len = MAX_PAYLOAD_LEN + 16'd1;
      else                len = 16'($urandom_range(MAX_PAYLOAD + 2, 65535));
      send_beat(CMD_BYTE, len[15:8]);
      send_beat(CMD_BYTE, len[7:0]);
      if (len > MAX_PAYLOAD_LEN) return;
      // now and then abandon the frame; the next start drops it
      cut  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len) : len + 1;
      xsum = 8'h00;
      for (i = 0; i < len; i++) begin
         if (i == cut) return;
         b = ($urandom_range(0, 15) == 0) ? TAG_BYTE : 8'($urandom);
         xsum = xsum ^ b;
         send_beat(CMD_BYTE, b);
      end
      if (cut == len) return;
      send_beat(CMD_BYTE, ($urandom_range(0, 3) != 0) ? xsum : 8'($urandom));
   endtask

   initial begin
      int unsigned phase_end;
      logic [15:0] new_limit;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      hunt_limit_now = HUNT_LIMIT_RST;
      foreach (directed_beats[k]) send_beat(directed_beats[k][8], directed_beats[k][7:0]);
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       new_limit = 16'd0;
            1:       new_limit = 16'd1;
            2:       new_limit = 16'd2;
            3:       new_limit = 16'hFFFF;
            4:       new_limit = 16'($urandom_range(3, 40));
            default: new_limit = 16'($urandom_range(3, 12));
         endcase
         set_hunt_limit(new_limit);
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) send_frame();
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
